>>> src/pjas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjas_pkg: shared types and constants of the admission scheduler
// Register indexes, field widths, queue geometry and the divider request and response.
// ----------------------------------------------------------------------------
package pjas_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_THREAD_LIMIT    = 2'd0;
    localparam logic [1:0] REG_FLOOR_LIMIT     = 2'd1;
    localparam logic [1:0] REG_CURVE_SPEED     = 2'd2;
    localparam logic [1:0] REG_PRIORITY_OFFSET = 2'd3;

    localparam logic [7:0] RST_THREAD_LIMIT    = 8'd10;
    localparam logic [7:0] RST_FLOOR_LIMIT     = 8'd2;
    localparam logic [7:0] RST_CURVE_SPEED     = 8'd7;
    localparam logic [7:0] RST_PRIORITY_OFFSET = 8'hF6;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // numerator magnitude: |limit - floor| * p < 2^8 * 2^8
    localparam int NUM_W = 17;
    localparam int DEN_W = 10;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> src/pjas_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjas_div: restoring unsigned divider
// One quotient bit per cycle; quotient of a NUM_W bit numerator.
// ----------------------------------------------------------------------------
module pjas_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  pjas_pkg::t_div_req    i_req,
    output pjas_pkg::t_div_rsp    o_rsp
);
    localparam int CNT_W = $clog2(pjas_pkg::NUM_W + 1);
    localparam int REM_W = pjas_pkg::DEN_W;

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [pjas_pkg::NUM_W-1:0]  r_quo, n_quo;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [pjas_pkg::DEN_W-1:0]  r_den, n_den;
    logic [REM_W:0]              w_shift;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        w_shift = {r_rem, r_quo[pjas_pkg::NUM_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(pjas_pkg::NUM_W);
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            // shift in one numerator bit, subtract if it fits
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = REM_W'(w_shift - {1'b0, r_den});
                n_quo = {r_quo[pjas_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[REM_W-1:0];
                n_quo = {r_quo[pjas_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without run");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !$past(i_req.start)) |-> (r_cnt == '0))
        else $error("divider count left over");
`endif

endmodule
`default_nettype wire

>>> src/priority_job_admission_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_job_admission_scheduler_unit: worker slot admission scheduler
// Starts, queues or drops submitted jobs and restarts waiters on a finish.
// ----------------------------------------------------------------------------
// Input item (s_axis): tdata = {job_tag, priority_req}, tuser = kind
// (0 submit, 1 finish). Result item (m_axis): tdata = {running_now,
// started_tag}, tuser = {dropped, queued, started} with started in bit 0.
// Configuration: i_cfg_we with i_cfg_index (0 thread_limit, 1 floor_limit,
// 2 curve_speed, 3 priority_offset) and i_cfg_data, taken on any edge with
// the enable high; a thread_limit below floor_limit is ignored.
// One item at a time. A submit that needs the curve goes from the test step
// through the bit-serial divider to its done, the compare and the result; one
// decided without the divider goes from the test step straight to done. A
// finish first scans the 16 queue entries one per cycle, then goes on like a
// submit, or straight to the result when the queue is empty.
// The result sits in an output register; s_axis_tready stays low until it
// is taken, so a stalled receiver holds the block. Reset clears the running
// count, arrival counter and all queue valid bits; the queue contents are
// not cleared. No clearing pass is needed, the block is ready right after
// reset.
module priority_job_admission_scheduler_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [7:0] priority_req, [23:8] job_tag
    input  wire         s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] started_tag, [23:16] running_now
    output logic [2:0]  m_axis_tuser,   // [0] started, [1] queued, [2] dropped
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    localparam int QW = pjas_pkg::QIDX_W;
    localparam int QC = pjas_pkg::QCNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_limit, r_floor, r_speed, r_offset;
    logic [7:0]  r_running, n_running;
    logic [15:0] r_arrival, n_arrival;

    logic [7:0]  r_qprio  [pjas_pkg::QUEUE_DEPTH];
    logic [15:0] r_qtag   [pjas_pkg::QUEUE_DEPTH];
    logic [15:0] r_qorder [pjas_pkg::QUEUE_DEPTH];
    logic [pjas_pkg::QUEUE_DEPTH-1:0] r_qvalid, n_qvalid;

    logic        r_kind;
    logic [7:0]  r_prio, n_prio;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_horder, n_horder;
    logic        r_hfound, n_hfound;
    logic [QW-1:0] r_head, n_head;
    logic [QC-1:0] r_scan, n_scan;
    logic        r_neg, n_neg;

    logic        r_ovalid, n_ovalid;
    logic        r_ostart, n_ostart;
    logic        r_oqueued, n_oqueued;
    logic        r_odrop, n_odrop;
    logic [15:0] r_otag, n_otag;

    pjas_pkg::t_div_req w_dreq;
    pjas_pkg::t_div_rsp w_drsp;

    logic          w_accept;
    logic signed [9:0]  w_p;
    logic signed [9:0]  w_diff;
    logic [8:0]    w_diff_mag;
    logic [16:0]   w_prod;
    logic          w_full;
    logic [QW-1:0] w_free;
    logic [QW-1:0] w_sidx;
    logic          w_ahead;
    logic [15:0]   w_odiff;
    logic signed [10:0] w_cap;
    logic signed [17:0] w_red;
    logic          w_write_q;
    logic [QW-1:0] w_wslot;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_sidx   = r_scan[QW-1:0];

    // shifted priority and numerator terms
    assign w_p        = 10'(signed'(r_prio)) + 10'(signed'(r_offset));
    assign w_diff     = signed'({2'b00, r_limit}) - signed'({2'b00, r_floor});
    assign w_diff_mag = w_diff[9] ? 9'(-w_diff) : w_diff[8:0];
    assign w_prod     = 17'(w_diff_mag[8:0]) * 17'(w_p[7:0]);
    assign w_cap      = 11'(signed'({2'b00, r_limit})) - 11'(signed'(w_red));
    assign w_red      = r_neg ? -18'(signed'({1'b0, w_drsp.quo}))
                              : 18'(signed'({1'b0, w_drsp.quo}));

    // lowest free slot
    always_comb begin
        w_full = 1'b1;
        w_free = '0;
        for (int i = pjas_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_qvalid[i]) begin
                w_full = 1'b0;
                w_free = QW'(i);
            end
        end
    end

    assign w_odiff = r_qorder[w_sidx] - r_horder;
    always_comb begin
        if (!r_hfound) begin
            w_ahead = 1'b1;
        end else if (r_qprio[w_sidx] != r_prio) begin
            w_ahead = signed'(r_qprio[w_sidx]) < signed'(r_prio);
        end else begin
            w_ahead = w_odiff[15];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        n_arrival = r_arrival;
        n_qvalid  = r_qvalid;
        n_prio    = r_prio;
        n_tag     = r_tag;
        n_horder  = r_horder;
        n_hfound  = r_hfound;
        n_head    = r_head;
        n_scan    = r_scan;
        n_neg     = r_neg;
        n_ovalid  = r_ovalid;
        n_ostart  = r_ostart;
        n_oqueued = r_oqueued;
        n_odrop   = r_odrop;
        n_otag    = r_otag;
        w_dreq    = '0;
        w_write_q = 1'b0;
        w_wslot   = w_free;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_prio    = s_axis_tdata[7:0];
                    n_tag     = s_axis_tdata[23:8];
                    n_ostart  = 1'b0;
                    n_oqueued = 1'b0;
                    n_odrop   = 1'b0;
                    n_otag    = '0;
                    n_hfound  = 1'b0;
                    n_scan    = '0;
                    if (s_axis_tuser == pjas_pkg::KIND_FINISH) begin
                        if (r_running != 8'd0) n_running = r_running - 8'd1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_TEST;
                    end
                end
            end
            ST_SCAN: begin
                // walk the queue, keep the best waiter in prio/tag/order
                if (r_qvalid[w_sidx] && w_ahead) begin
                    n_hfound = 1'b1;
                    n_head   = w_sidx;
                    n_prio   = r_qprio[w_sidx];
                    n_tag    = r_qtag[w_sidx];
                    n_horder = r_qorder[w_sidx];
                end
                n_scan = r_scan + 1'b1;
                if (r_scan == QC'(pjas_pkg::QUEUE_DEPTH - 1)) begin
                    n_state = r_hfound || r_qvalid[w_sidx] ? ST_TEST : ST_OUT;
                    n_ovalid = !(r_hfound || r_qvalid[w_sidx]);
                end
            end
            ST_TEST: begin
                if (r_running >= r_limit) begin
                    n_state = ST_DONE;
                    n_ostart = 1'b0;
                end else if (w_p[9]) begin
                    n_ostart = 1'b1;
                    n_state  = ST_DONE;
                end else if ((r_speed == 8'd0) && (w_p == 10'sd0)) begin
                    n_ostart = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    n_neg = w_diff[9];
                    w_dreq.start = 1'b1;
                    w_dreq.num   = w_prod;
                    w_dreq.den   = 10'(r_speed) + 10'(w_p[7:0]);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    n_ostart = w_cap > 11'(signed'({3'b000, r_running}));
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (r_ostart) begin
                    n_running = r_running + 8'd1;
                    n_otag    = r_tag;
                    if (r_kind == pjas_pkg::KIND_FINISH) n_qvalid[r_head] = 1'b0;
                end else if (r_kind == pjas_pkg::KIND_SUBMIT) begin
                    if (w_full) begin
                        n_odrop = 1'b1;
                    end else begin
                        n_arrival = r_arrival + 16'd1;
                        w_write_q = 1'b1;
                        n_qvalid[w_free] = 1'b1;
                        n_oqueued = 1'b1;
                    end
                end
                n_ovalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_running <= '0;
            r_arrival <= '0;
            r_qvalid  <= '0;
            r_ovalid  <= 1'b0;
            r_limit   <= pjas_pkg::RST_THREAD_LIMIT;
            r_floor   <= pjas_pkg::RST_FLOOR_LIMIT;
            r_speed   <= pjas_pkg::RST_CURVE_SPEED;
            r_offset  <= pjas_pkg::RST_PRIORITY_OFFSET;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_arrival <= n_arrival;
            r_qvalid  <= n_qvalid;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pjas_pkg::REG_THREAD_LIMIT:
                        if (i_cfg_data >= r_floor) r_limit <= i_cfg_data;
                    pjas_pkg::REG_FLOOR_LIMIT:     r_floor  <= i_cfg_data;
                    pjas_pkg::REG_CURVE_SPEED:     r_speed  <= i_cfg_data;
                    pjas_pkg::REG_PRIORITY_OFFSET: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (w_accept) r_kind <= s_axis_tuser;
        r_prio    <= n_prio;
        r_tag     <= n_tag;
        r_horder  <= n_horder;
        r_hfound  <= n_hfound;
        r_head    <= n_head;
        r_scan    <= n_scan;
        r_neg     <= n_neg;
        r_ostart  <= n_ostart;
        r_oqueued <= n_oqueued;
        r_odrop   <= n_odrop;
        r_otag    <= n_otag;
        if (w_write_q) begin
            r_qprio[w_wslot]  <= r_prio;
            r_qtag[w_wslot]   <= r_tag;
            r_qorder[w_wslot] <= r_arrival + 16'd1;
        end
    end

    pjas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_running, r_otag};
    assign m_axis_tuser  = {r_odrop, r_oqueued, r_ostart};

`ifndef SYNTHESIS
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_OUT))
        else $error("result shown outside output state");
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $onehot0({r_ostart, r_oqueued, r_odrop}))
        else $error("conflicting result flags");
    a_submit_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_kind == pjas_pkg::KIND_SUBMIT) |->
            $onehot({r_ostart, r_oqueued, r_odrop}))
        else $error("submit without outcome");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odrop) |-> (&r_qvalid))
        else $error("drop with free slot");
`endif

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: admission scheduler testbench
// Drives submit and finish items through the stream ports under several
// idling phases and register settings, predicts every result with a local
// slot-admission model and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic        started;
        logic [15:0] started_tag;
        logic        queued;
        logic        dropped;
        logic [7:0]  running_now;
    } t_outcome;

    typedef struct {
        logic        kind;
        logic [7:0]  prio;
        logic [15:0] tag;
        logic        has_known;
        t_outcome    known;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;
    wire  [2:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    priority_job_admission_scheduler_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  lim_q, floor_q, speed_q, offset_q;
    logic [7:0]  running_q;
    logic [15:0] arrival_q;
    logic [7:0]  wprio [pjas_pkg::QUEUE_DEPTH];
    logic [15:0] wtag [pjas_pkg::QUEUE_DEPTH];
    logic [15:0] worder [pjas_pkg::QUEUE_DEPTH];
    logic        wvalid [pjas_pkg::QUEUE_DEPTH];

    t_outcome    pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          starts_seen = 0;
    int          drops_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;

    function automatic bit admits(logic [7:0] prio);
        int p, den, reduce;
        if (running_q >= lim_q) return 1'b0;
        p = $signed(prio) + $signed(offset_q);
        if (p >= 0) begin
            den = int'(speed_q) + p;
            reduce = 0;
            if (den > 0) reduce = ((int'(lim_q) - int'(floor_q)) * p) / den;
            if (int'(lim_q) - reduce <= int'(running_q)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit goes_first(int a, int b);
        logic [15:0] diff;
        if ($signed(wprio[a]) != $signed(wprio[b]))
            return $signed(wprio[a]) < $signed(wprio[b]);
        diff = worder[a] - worder[b];
        return diff[15];
    endfunction

    function automatic t_outcome admit_job(logic kind, logic [7:0] prio, logic [15:0] tag);
        t_outcome r;
        int slot, head;
        r = '0;
        if (kind == pjas_pkg::KIND_SUBMIT) begin
            if (admits(prio)) begin
                running_q++;
                r.started = 1'b1;
                r.started_tag = tag;
            end else begin
                slot = -1;
                for (int i = pjas_pkg::QUEUE_DEPTH - 1; i >= 0; i--)
                    if (!wvalid[i]) slot = i;
                if (slot >= 0) begin
                    arrival_q++;
                    wprio[slot] = prio;
                    wtag[slot] = tag;
                    worder[slot] = arrival_q;
                    wvalid[slot] = 1'b1;
                    r.queued = 1'b1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else begin
            head = -1;
            if (running_q > 0) running_q--;
            for (int i = 0; i < pjas_pkg::QUEUE_DEPTH; i++)
                if (wvalid[i] && (head < 0 || goes_first(i, head))) head = i;
            if (head >= 0 && admits(wprio[head])) begin
                running_q++;
                wvalid[head] = 1'b0;
                r.started = 1'b1;
                r.started_tag = wtag[head];
            end
        end
        r.running_now = running_q;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, field, got, want);
        errors++;
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        t_outcome want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result with nothing pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.started)
                    report_mismatch("started", int'(m_axis_tuser[0]),
                                    int'(want.started));
                if (m_axis_tdata[15:0] !== want.started_tag)
                    report_mismatch("started_tag", int'(m_axis_tdata[15:0]),
                                    int'(want.started_tag));
                if (m_axis_tuser[1] !== want.queued)
                    report_mismatch("queued", int'(m_axis_tuser[1]),
                                    int'(want.queued));
                if (m_axis_tuser[2] !== want.dropped)
                    report_mismatch("dropped", int'(m_axis_tuser[2]),
                                    int'(want.dropped));
                if (m_axis_tdata[23:16] !== want.running_now)
                    report_mismatch("running_now", int'(m_axis_tdata[23:16]),
                                    int'(want.running_now));
                starts_seen += int'(want.started);
                drops_seen += int'(want.dropped);
            end
            results_seen++;
        end
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n || hold_off)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays up after an accept until the next item or drain drops it
    task automatic send_item(logic kind, logic [7:0] prio, logic [15:0] tag,
                             bit has_known, t_outcome known);
        t_outcome want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {tag, prio};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = admit_job(kind, prio, tag);
        if (has_known && want !== known) begin
            $display("directed row %0d: predictor disagrees with typed result", items_sent);
            errors++;
        end
        pending_results.push_back(has_known ? known : want);
        items_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            pjas_pkg::REG_THREAD_LIMIT:    if (value >= floor_q) lim_q = value;
            pjas_pkg::REG_FLOOR_LIMIT:     floor_q = value;
            pjas_pkg::REG_CURVE_SPEED:     speed_q = value;
            pjas_pkg::REG_PRIORITY_OFFSET: offset_q = value;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_outcome mk(logic st, logic [15:0] tg, logic q, logic d,
                                    logic [7:0] run);
        t_outcome r;
        r.started = st; r.started_tag = tg; r.queued = q; r.dropped = d;
        r.running_now = run;
        return r;
    endfunction

    // mostly submits with clustered priorities, finishes keep the queue moving
    task automatic random_items(int count, int finish_pct);
        logic [7:0] prio;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) prio = 8'($urandom);
            else prio = 8'($urandom_range(20)) - 8'd5;
            if ($urandom_range(99) < finish_pct)
                send_item(pjas_pkg::KIND_FINISH, 8'($urandom), 16'($urandom),
                          1'b0, '0);
            else
                send_item(pjas_pkg::KIND_SUBMIT, prio, 16'($urandom), 1'b0, '0);
        end
    endtask

    t_row directed[$];

    initial begin
        t_outcome none;
        none = '0;
        lim_q = pjas_pkg::RST_THREAD_LIMIT; floor_q = pjas_pkg::RST_FLOOR_LIMIT;
        speed_q = pjas_pkg::RST_CURVE_SPEED; offset_q = pjas_pkg::RST_PRIORITY_OFFSET;
        running_q = '0; arrival_q = '0;
        for (int i = 0; i < pjas_pkg::QUEUE_DEPTH; i++) begin
            wvalid[i] = 1'b0; wprio[i] = '0; wtag[i] = '0; worder[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // finish with nothing running, extremes, then fill limit at reset config
        directed.push_back('{pjas_pkg::KIND_FINISH, 8'hAA, 16'hFFFF, 1'b1,
                             mk(1'b0, 16'h0000, 1'b0, 1'b0, 8'd0)});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'h80, 16'hFFFF, 1'b1,
                             mk(1'b1, 16'hFFFF, 1'b0, 1'b0, 8'd1)});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'h7F, 16'h0000, 1'b0, none});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'd10, 16'h5555, 1'b0, none});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'd0, 16'hAAAA, 1'b0, none});
        for (int i = 0; i < 8; i++)
            directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'hF0, 16'(i + 16'h100),
                                 1'b0, none});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'h7F, 16'h0BAD, 1'b0, none});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'd20, 16'h0C0D, 1'b0, none});
        directed.push_back('{pjas_pkg::KIND_SUBMIT, 8'd20, 16'h0C0E, 1'b0, none});
        for (int i = 0; i < 4; i++)
            directed.push_back('{pjas_pkg::KIND_FINISH, 8'h00, 16'h0, 1'b0, none});
        foreach (directed[i])
            send_item(directed[i].kind, directed[i].prio, directed[i].tag,
                      directed[i].has_known, directed[i].known);
        drain();

        // fill the queue past its depth to see drops
        for (int i = 0; i < 24; i++)
            send_item(pjas_pkg::KIND_SUBMIT, 8'h7F, 16'(i), 1'b0, none);
        drain();

        // phase 1: reset config, no idling
        random_items(250, 40);
        drain();

        // ignored limit write (below floor), then floor above limit, zero speed
        write_reg(pjas_pkg::REG_FLOOR_LIMIT, 8'd6);
        write_reg(pjas_pkg::REG_THREAD_LIMIT, 8'd4);
        write_reg(pjas_pkg::REG_FLOOR_LIMIT, 8'd255);
        write_reg(pjas_pkg::REG_CURVE_SPEED, 8'd0);
        write_reg(pjas_pkg::REG_PRIORITY_OFFSET, 8'd0);
        send_idle_pct = 87;
        send_item(pjas_pkg::KIND_SUBMIT, 8'd0, 16'h1234, 1'b0, none);
        random_items(250, 45);
        drain();

        // extreme register values, receiver stalling
        write_reg(pjas_pkg::REG_FLOOR_LIMIT, 8'd0);
        write_reg(pjas_pkg::REG_THREAD_LIMIT, 8'd255);
        write_reg(pjas_pkg::REG_CURVE_SPEED, 8'd255);
        write_reg(pjas_pkg::REG_PRIORITY_OFFSET, 8'h7F);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        random_items(300, 20);
        drain();

        // tight limit, both sides idle
        write_reg(pjas_pkg::REG_THREAD_LIMIT, 8'd3);
        write_reg(pjas_pkg::REG_FLOOR_LIMIT, 8'd2);
        write_reg(pjas_pkg::REG_CURVE_SPEED, 8'd1);
        write_reg(pjas_pkg::REG_PRIORITY_OFFSET, 8'h80);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        random_items(300, 45);
        drain();

        // long receiver hold-off while the sender keeps offering items
        write_reg(pjas_pkg::REG_THREAD_LIMIT, 8'd2);
        write_reg(pjas_pkg::REG_PRIORITY_OFFSET, 8'hF6);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_items(30, 40);
        join
        drain();

        write_reg(pjas_pkg::REG_THREAD_LIMIT, pjas_pkg::RST_THREAD_LIMIT);
        write_reg(pjas_pkg::REG_CURVE_SPEED, pjas_pkg::RST_CURVE_SPEED);
        random_items(550, 45);
        drain();

        $display("covered %0d items under %0s idling phases: %0d starts, %0d drops",
                 items_sent, "five", starts_seen, drops_seen);
        $display("register settings included extremes, floor above limit and zero speed");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
